// ===== hw/rtl/khc_pkg.sv =====
// Package: sizes, table port structs and sequencer states for the keyed hit counter.
package khc_pkg;

    localparam int TABLE_ENTRIES = 8192;
    localparam int TOP_COUNT     = 12;

    localparam int KEY_W  = 32;
    localparam int CNT_W  = 32;
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
    localparam int RANK_W = (TOP_COUNT > 16) ? $clog2(TOP_COUNT) : 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RSCAN,
        ST_PSCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [KEY_W-1:0] wr_key;
        logic [CNT_W-1:0] wr_fcnt;
        logic [CNT_W-1:0] wr_ucnt;
    } t_tbl_req;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] fcnt;
        logic [CNT_W-1:0] ucnt;
    } t_tbl_rsp;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// ===== hw/rtl/khc_table.sv =====
// Entry table: key and two counters per entry, one read and one write port.
module khc_table (
    input  logic              i_clk,
    input  khc_pkg::t_tbl_req i_req,
    output khc_pkg::t_tbl_rsp o_rsp
);
    import khc_pkg::*;

    logic [KEY_W-1:0] r_key_mem  [TABLE_ENTRIES];
    logic [CNT_W-1:0] r_fcnt_mem [TABLE_ENTRIES];
    logic [CNT_W-1:0] r_ucnt_mem [TABLE_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_key_mem[i_req.wr_addr]  <= i_req.wr_key;
            r_fcnt_mem[i_req.wr_addr] <= i_req.wr_fcnt;
            r_ucnt_mem[i_req.wr_addr] <= i_req.wr_ucnt;
        end
        if (i_req.rd_en) begin
            o_rsp.key  <= r_key_mem[i_req.rd_addr];
            o_rsp.fcnt <= r_fcnt_mem[i_req.rd_addr];
            o_rsp.ucnt <= r_ucnt_mem[i_req.rd_addr];
        end
    end

endmodule

// ===== hw/rtl/keyed_hit_counter_top_k.sv =====
// Top level: keyed hit counter with a sequencer that scans the entry table.
//
// Input channel (i_valid/o_ready) takes one command item at a time; o_ready
// is high only while the sequencer is idle. A record item searches the
// filled part of the table, one entry per cycle through the single table
// read port, then writes the bumped counter (or a new entry, while the
// table has room); a hit ends the search early. Key zero is ignored.
// A report item runs one full scan per ranked result, at most TOP_COUNT
// scans; one more finds nothing when fewer entries qualify.
// Results leave on o_valid/i_ready, one per handshake, rank 0 first, with
// o_last on the final one. A result is held until the next scan or the rank
// limit shows if it is last; the block waits as long as the receiver stalls.
// Ties rank the earlier-inserted entry first. Counters saturate.
// Reset clears the fill count and the sequencer; the table contents are not
// cleared, since only filled entries are ever read. No clearing pass.
module keyed_hit_counter_top_k (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_command,
    input  logic [khc_pkg::KEY_W-1:0]  i_key,
    input  logic                       i_depth_bound,
    input  logic                       i_bucket_select,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [khc_pkg::KEY_W-1:0]  o_report_key,
    output logic [khc_pkg::CNT_W-1:0]  o_report_count,
    output logic [3:0]                 o_rank,
    output logic                       o_last
);
    import khc_pkg::*;

    t_state r_state, n_state;
    t_tbl_req tbl_req;
    t_tbl_rsp tbl_rsp;

    logic [USED_W-1:0] r_used, n_used;
    logic [USED_W-1:0] r_addr, n_addr;
    logic              r_rv, n_rv;
    logic [IDX_W-1:0]  r_ridx, n_ridx;
    logic [KEY_W-1:0]  r_key, n_key;
    logic              r_flag, n_flag;
    logic              r_bsel, n_bsel;
    // best of the current pass
    logic              r_found, n_found;
    logic [CNT_W-1:0]  r_bcnt, n_bcnt;
    logic [IDX_W-1:0]  r_bidx, n_bidx;
    logic [KEY_W-1:0]  r_bkey, n_bkey;
    // previous pick, not yet shown
    logic              r_hprev, n_hprev;
    logic [CNT_W-1:0]  r_pcnt, n_pcnt;
    logic [IDX_W-1:0]  r_pidx, n_pidx;
    logic [KEY_W-1:0]  r_pkey, n_pkey;
    logic [RANK_W-1:0] r_prank, n_prank;
    // output register
    logic [KEY_W-1:0]  r_okey, n_okey;
    logic [CNT_W-1:0]  r_ocnt, n_ocnt;
    logic [RANK_W-1:0] r_orank, n_orank;
    logic              r_olast, n_olast;

    logic             in_acc, out_acc, issue, scan_done, hit, elig, take;
    logic [CNT_W-1:0] sel_cnt;

    assign in_acc    = i_valid && o_ready;
    assign out_acc   = o_valid && i_ready;
    assign issue     = r_addr < r_used;
    assign scan_done = !issue && !r_rv;
    assign hit       = r_rv && (tbl_rsp.key == r_key);
    assign sel_cnt   = r_bsel ? tbl_rsp.fcnt : tbl_rsp.ucnt;
    assign elig      = r_rv && (sel_cnt != '0) &&
                       (!r_hprev || (sel_cnt < r_pcnt) ||
                        ((sel_cnt == r_pcnt) && (r_ridx > r_pidx)));
    assign take      = elig && (!r_found || (sel_cnt > r_bcnt));

    khc_table u_table (
        .i_clk (i_clk),
        .i_req (tbl_req),
        .o_rsp (tbl_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_command == CMD_REPORT) begin
                        n_state = ST_PSCAN;
                    end else if (i_key != '0) begin
                        n_state = ST_RSCAN;
                    end
                end
            end
            ST_RSCAN: begin
                if (hit || scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PSCAN: begin
                if (scan_done) begin
                    if (r_found) begin
                        if (r_hprev || (TOP_COUNT == 1)) begin
                            n_state = ST_EMIT;
                        end
                    end else begin
                        n_state = r_hprev ? ST_EMIT : ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (out_acc) begin
                    if (r_olast) begin
                        n_state = ST_IDLE;
                    end else if (r_prank != RANK_W'(TOP_COUNT - 1)) begin
                        n_state = ST_PSCAN;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and table port
    always_comb begin
        n_used  = r_used;
        n_addr  = r_addr;
        n_rv    = 1'b0;
        n_ridx  = r_ridx;
        n_key   = r_key;
        n_flag  = r_flag;
        n_bsel  = r_bsel;
        n_found = r_found;
        n_bcnt  = r_bcnt;
        n_bidx  = r_bidx;
        n_bkey  = r_bkey;
        n_hprev = r_hprev;
        n_pcnt  = r_pcnt;
        n_pidx  = r_pidx;
        n_pkey  = r_pkey;
        n_prank = r_prank;
        n_okey  = r_okey;
        n_ocnt  = r_ocnt;
        n_orank = r_orank;
        n_olast = r_olast;
        tbl_req = '0;
        tbl_req.rd_addr = r_addr[IDX_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_key   = i_key;
                    n_flag  = i_depth_bound;
                    n_bsel  = i_bucket_select;
                    n_addr  = '0;
                    n_found = 1'b0;
                    n_hprev = 1'b0;
                    n_prank = '0;
                end
            end
            ST_RSCAN: begin
                if (issue && !hit) begin
                    tbl_req.rd_en = 1'b1;
                    n_addr = r_addr + 1'b1;
                    n_rv   = 1'b1;
                    n_ridx = r_addr[IDX_W-1:0];
                end
                if (hit) begin
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_addr = r_ridx;
                    tbl_req.wr_key  = r_key;
                    tbl_req.wr_fcnt = r_flag ? sat_inc(tbl_rsp.fcnt) : tbl_rsp.fcnt;
                    tbl_req.wr_ucnt = r_flag ? tbl_rsp.ucnt : sat_inc(tbl_rsp.ucnt);
                end else if (scan_done && (r_used < USED_W'(TABLE_ENTRIES))) begin
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_addr = r_used[IDX_W-1:0];
                    tbl_req.wr_key  = r_key;
                    tbl_req.wr_fcnt = CNT_W'(r_flag);
                    tbl_req.wr_ucnt = CNT_W'(!r_flag);
                    n_used = r_used + 1'b1;
                end
            end
            ST_PSCAN: begin
                if (issue) begin
                    tbl_req.rd_en = 1'b1;
                    n_addr = r_addr + 1'b1;
                    n_rv   = 1'b1;
                    n_ridx = r_addr[IDX_W-1:0];
                end
                if (take) begin
                    n_found = 1'b1;
                    n_bcnt  = sel_cnt;
                    n_bidx  = r_ridx;
                    n_bkey  = tbl_rsp.key;
                end
                if (scan_done) begin
                    n_addr  = '0;
                    n_found = 1'b0;
                    if (r_found) begin
                        if (r_hprev) begin
                            // show the previous pick, keep the new one pending
                            n_okey  = r_pkey;
                            n_ocnt  = r_pcnt;
                            n_orank = r_prank;
                            n_olast = 1'b0;
                            n_prank = r_prank + 1'b1;
                        end else begin
                            n_okey  = r_bkey;
                            n_ocnt  = r_bcnt;
                            n_orank = '0;
                            n_olast = 1'b1;
                        end
                        n_hprev = 1'b1;
                        n_pcnt  = r_bcnt;
                        n_pidx  = r_bidx;
                        n_pkey  = r_bkey;
                    end else begin
                        n_okey  = r_pkey;
                        n_ocnt  = r_pcnt;
                        n_orank = r_prank;
                        n_olast = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (out_acc && !r_olast && (r_prank == RANK_W'(TOP_COUNT - 1))) begin
                    n_okey  = r_pkey;
                    n_ocnt  = r_pcnt;
                    n_orank = r_prank;
                    n_olast = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used  <= '0;
            r_rv    <= 1'b0;
            r_found <= 1'b0;
            r_hprev <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_rv    <= n_rv;
            r_found <= n_found;
            r_hprev <= n_hprev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_ridx  <= n_ridx;
        r_key   <= n_key;
        r_flag  <= n_flag;
        r_bsel  <= n_bsel;
        r_bcnt  <= n_bcnt;
        r_bidx  <= n_bidx;
        r_bkey  <= n_bkey;
        r_pcnt  <= n_pcnt;
        r_pidx  <= n_pidx;
        r_pkey  <= n_pkey;
        r_prank <= n_prank;
        r_okey  <= n_okey;
        r_ocnt  <= n_ocnt;
        r_orank <= n_orank;
        r_olast <= n_olast;
    end

    assign o_ready        = (r_state == ST_IDLE);
    assign o_valid        = (r_state == ST_EMIT);
    assign o_report_key   = r_okey;
    assign o_report_count = r_ocnt;
    assign o_rank         = r_orank[3:0];
    assign o_last         = r_olast;

endmodule

// ===== hw/rtl/khc_checker.sv =====
// Port checker for the keyed hit counter, bound to the top level.
module khc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_report_key,
    input logic [31:0] o_report_count,
    input logic [3:0]  o_rank,
    input logic        o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_report_key) &&
        $stable(o_report_count) && $stable(o_rank) && $stable(o_last))
        else $error("stalled item changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input ready while a result is pending");

    a_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> !o_ready)
        else $error("report ended without last");

    a_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_report_count != 32'd0)
        else $error("zero count reported");

endmodule

bind keyed_hit_counter_top_k khc_checker u_khc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_report_key   (o_report_key),
    .o_report_count (o_report_count),
    .o_rank         (o_rank),
    .o_last         (o_last)
);

// ===== tb/tb_keyed_hit_counter_top_k.sv =====
// Testbench for the keyed hit counter: random records and top-k reports checked against a predictor.
module tb_keyed_hit_counter_top_k;
    timeunit 1ns;
    timeprecision 1ps;
    import khc_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 64;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
        logic [3:0]       rank;
        logic             last;
    } t_ranked;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic             i_command;
    logic [KEY_W-1:0] i_key;
    logic             i_depth_bound;
    logic             i_bucket_select;
    logic             o_valid;
    logic             i_ready;
    logic [KEY_W-1:0] o_report_key;
    logic [CNT_W-1:0] o_report_count;
    logic [3:0]       o_rank;
    logic             o_last;

    // predictor copy of the table, in insertion order
    logic [KEY_W-1:0] tbl_keys[$];
    logic [CNT_W-1:0] tbl_fcnt[$];
    logic [CNT_W-1:0] tbl_ucnt[$];
    t_ranked          pending_results[$];
    logic [KEY_W-1:0] hot_keys[$];

    int errors;
    int snd_idle_pct;
    int rcv_idle_pct;
    int hold_cycles;
    int quiet_cycles;

    keyed_hit_counter_top_k i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_key          (i_key),
        .i_depth_bound  (i_depth_bound),
        .i_bucket_select(i_bucket_select),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_report_key   (o_report_key),
        .o_report_count (o_report_count),
        .o_rank         (o_rank),
        .o_last         (o_last)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    task automatic record_hit(input logic [KEY_W-1:0] key, input logic flagged);
        int slot;
        slot = -1;
        if (key == '0) return;
        foreach (tbl_keys[i]) begin
            if (tbl_keys[i] == key) begin
                slot = i;
                break;
            end
        end
        if (slot < 0) begin
            if (tbl_keys.size() >= TABLE_ENTRIES) return;
            tbl_keys.push_back(key);
            tbl_fcnt.push_back('0);
            tbl_ucnt.push_back('0);
            slot = tbl_keys.size() - 1;
        end
        if (flagged) tbl_fcnt[slot] = bump(tbl_fcnt[slot]);
        else tbl_ucnt[slot] = bump(tbl_ucnt[slot]);
    endtask

    // selection by repeated scans; ties keep the earlier entry
    task automatic rank_top(input logic flagged);
        logic [CNT_W-1:0] prev_cnt;
        logic [CNT_W-1:0] best_cnt;
        logic [CNT_W-1:0] c;
        int prev_idx;
        int best_idx;
        int n;
        int first;
        t_ranked r;
        prev_cnt = '0;
        prev_idx = -1;
        n = 0;
        first = pending_results.size();
        while (n < TOP_COUNT) begin
            best_idx = -1;
            best_cnt = '0;
            for (int i = 0; i < tbl_keys.size(); i++) begin
                c = flagged ? tbl_fcnt[i] : tbl_ucnt[i];
                if (c == '0) continue;
                if (prev_idx >= 0 && !(c < prev_cnt || (c == prev_cnt && i > prev_idx)))
                    continue;
                if (best_idx < 0 || c > best_cnt) begin
                    best_idx = i;
                    best_cnt = c;
                end
            end
            if (best_idx < 0) break;
            r.key = tbl_keys[best_idx];
            r.count = best_cnt;
            r.rank = n[3:0];
            r.last = 1'b0;
            pending_results.push_back(r);
            prev_cnt = best_cnt;
            prev_idx = best_idx;
            n++;
        end
        if (n > 0) pending_results[first + n - 1].last = 1'b1;
    endtask

    // called right after a rising edge
    task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key,
                             input logic db, input logic bs);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_command       <= cmd;
        i_key           <= key;
        i_depth_bound   <= db;
        i_bucket_select <= bs;
        do @(posedge i_clk); while (!o_ready);
        if (cmd == CMD_RECORD) record_hit(key, db);
        else rank_top(bs);
    endtask

    // drop valid at once so the last item is not taken twice
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 4) return '0;
        if (r < 22) return $urandom;
        // skewed toward the front of the pool so counts spread out
        return hot_keys[$urandom_range(0, $urandom_range(hot_keys.size() - 1))];
    endfunction

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 14)
                send_item(CMD_REPORT, $urandom, 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            else
                send_item(CMD_RECORD, pick_key(), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
        end
    endtask

    task automatic test_directed();
        send_item(CMD_REPORT, '0, 1'b0, 1'b0);          // empty table
        send_item(CMD_REPORT, '1, 1'b1, 1'b1);
        send_item(CMD_RECORD, '0, 1'b1, 1'b0);          // key zero ignored
        send_item(CMD_RECORD, '0, 1'b0, 1'b1);
        send_item(CMD_REPORT, '0, 1'b0, 1'b1);
        send_item(CMD_RECORD, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_item(CMD_RECORD, 32'h0000_0001, 1'b1, 1'b1);
        send_item(CMD_RECORD, 32'h8000_0000, 1'b0, 1'b0);
        send_item(CMD_RECORD, 32'h0000_0001, 1'b0, 1'b1);
        send_item(CMD_REPORT, 32'h1234_5678, 1'b1, 1'b1); // tie: insertion order
        send_item(CMD_REPORT, 32'h0, 1'b0, 1'b0);
        send_item(CMD_RECORD, 32'h8000_0000, 1'b0, 1'b0);
        send_item(CMD_RECORD, 32'h8000_0000, 1'b0, 1'b0);
        send_item(CMD_RECORD, 32'h7FFF_FFFF, 1'b1, 1'b0);
        send_item(CMD_RECORD, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_item(CMD_REPORT, '1, 1'b1, 1'b0);
        send_item(CMD_REPORT, '0, 1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_random(input int n, input int snd_pct, input int rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        send_random(n);
    endtask

    // receiver stalls long, so a pending report result holds off the next commands
    task automatic test_backpressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_cycles = 600;
        for (int i = 0; i < 6; i++) begin
            send_item(CMD_REPORT, $urandom, 1'($urandom_range(1)), i[0]);
            send_item(CMD_RECORD, pick_key(), 1'($urandom_range(1)), 1'b0);
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_ranked exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result key=%h count=%0d", o_report_key, o_report_count);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_report_key !== exp_r.key) begin
                    $error("report_key exp %h got %h", exp_r.key, o_report_key);
                    errors++;
                end
                if (o_report_count !== exp_r.count) begin
                    $error("report_count exp %0d got %0d", exp_r.count, o_report_count);
                    errors++;
                end
                if (o_rank !== exp_r.rank) begin
                    $error("rank exp %0d got %0d", exp_r.rank, o_rank);
                    errors++;
                end
                if (o_last !== exp_r.last) begin
                    $error("last exp %0d got %0d", exp_r.last, o_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        errors = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = CMD_RECORD;
        i_key = '0;
        i_depth_bound = 1'b0;
        i_bucket_select = 1'b0;
        hot_keys = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF};
        repeat (28) hot_keys.push_back($urandom | 32'h1);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(170, 16, 80);
        test_random(170, 80, 16);
        wait_drained();
        test_backpressure();
        test_random(150, 0, 0);
        wait_drained();

        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/khc_pkg.sv
hw/rtl/khc_table.sv
hw/rtl/keyed_hit_counter_top_k.sv
hw/rtl/khc_checker.sv
tb/tb_keyed_hit_counter_top_k.sv
